@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define SCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// shared types and constants of the strongly connected components block
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam logic [5:0] VCOUNT_RESET = 6'd32;

    localparam logic [1:0] OP_ARC   = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SEQ_RD,
        ST_SEQ_CHK,
        ST_STEP,
        ST_POP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic clear_rows;
        logic latch_add;
        logic add_rd;
        logic add_wr;
        logic add_swap;
        logic run_init;
        logic start_tree;
        logic push;
        logic finish;
        logic pop;
        logic next_seq;
        logic begin_pass2;
        logic begin_scan;
        logic scan_next;
        logic emit_begin;
        logic emit_dec;
        logic load_out;
        logic chunk_end;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic       add_ok;
        logic       edge_op;
        logic       swapped;
        logic       pass2;
        logic       seq_white;
        logic       cand_any;
        logic       sp_one;
        logic       i_last;
        logic       root_flag;
        logic       emit_done;
        logic       j_last;
        logic       out_free;
    } status_t;

endpackage

@@ rtl/scc_ram.sv @@
// ----------------------------------------------------------------------------
// scc_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/scc_ctrl.sv @@
// ----------------------------------------------------------------------------
// scc_ctrl
// sequencer for loading, both search passes and result readout
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  scc_pkg::status_t  status,
    output scc_pkg::cmd_t     cmd
);

    scc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (status.in_op == scc_pkg::OP_RUN) begin
                        state_next = scc_pkg::ST_SEQ_RD;
                    end else if ((status.in_op == scc_pkg::OP_ARC ||
                                  status.in_op == scc_pkg::OP_EDGE) && status.add_ok) begin
                        state_next = scc_pkg::ST_ADD_RD;
                    end
                end
            end
            scc_pkg::ST_ADD_RD: state_next = scc_pkg::ST_ADD_WR;
            scc_pkg::ST_ADD_WR: begin
                if (status.edge_op && !status.swapped) state_next = scc_pkg::ST_ADD_RD;
                else state_next = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_SEQ_RD: state_next = scc_pkg::ST_SEQ_CHK;
            scc_pkg::ST_SEQ_CHK: begin
                if (status.seq_white) state_next = scc_pkg::ST_STEP;
                else if (!status.i_last) state_next = scc_pkg::ST_SEQ_RD;
                else if (!status.pass2) state_next = scc_pkg::ST_SEQ_RD;
                else state_next = scc_pkg::ST_SCAN_RD;
            end
            scc_pkg::ST_STEP: begin
                if (status.cand_any) state_next = scc_pkg::ST_STEP;
                else if (!status.sp_one) state_next = scc_pkg::ST_POP;
                else if (!status.i_last) state_next = scc_pkg::ST_SEQ_RD;
                else if (!status.pass2) state_next = scc_pkg::ST_SEQ_RD;
                else state_next = scc_pkg::ST_SCAN_RD;
            end
            scc_pkg::ST_POP: state_next = scc_pkg::ST_STEP;
            scc_pkg::ST_SCAN_RD: state_next = scc_pkg::ST_SCAN_CHK;
            scc_pkg::ST_SCAN_CHK: begin
                if (status.root_flag) state_next = scc_pkg::ST_EMIT_RD;
                else state_next = scc_pkg::ST_SCAN_RD;
            end
            scc_pkg::ST_EMIT_RD: state_next = scc_pkg::ST_EMIT_OUT;
            scc_pkg::ST_EMIT_OUT: begin
                if (status.out_free) begin
                    if (!status.emit_done) state_next = scc_pkg::ST_EMIT_RD;
                    else if (status.j_last) state_next = scc_pkg::ST_IDLE;
                    else state_next = scc_pkg::ST_SCAN_RD;
                end
            end
            default: state_next = scc_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            scc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (status.in_op)
                        scc_pkg::OP_CLEAR: cmd.clear_rows = 1'b1;
                        scc_pkg::OP_RUN:   cmd.run_init   = 1'b1;
                        default:           cmd.latch_add  = status.add_ok;
                    endcase
                end
            end
            scc_pkg::ST_ADD_RD: cmd.add_rd = 1'b1;
            scc_pkg::ST_ADD_WR: begin
                cmd.add_wr   = 1'b1;
                cmd.add_swap = status.edge_op && !status.swapped;
            end
            scc_pkg::ST_SEQ_CHK: begin
                if (status.seq_white) begin
                    cmd.start_tree = 1'b1;
                end else begin
                    cmd.next_seq    = 1'b1;
                    cmd.begin_pass2 = status.i_last && !status.pass2;
                    cmd.begin_scan  = status.i_last && status.pass2;
                end
            end
            scc_pkg::ST_STEP: begin
                if (status.cand_any) begin
                    cmd.push = 1'b1;
                end else begin
                    cmd.finish = 1'b1;
                    if (status.sp_one) begin
                        cmd.next_seq    = 1'b1;
                        cmd.begin_pass2 = status.i_last && !status.pass2;
                        cmd.begin_scan  = status.i_last && status.pass2;
                    end
                end
            end
            scc_pkg::ST_POP: cmd.pop = 1'b1;
            scc_pkg::ST_SCAN_CHK: begin
                if (status.root_flag) cmd.emit_begin = 1'b1;
                else cmd.scan_next = 1'b1;
            end
            scc_pkg::ST_EMIT_OUT: begin
                if (status.out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.chunk_end = status.emit_done;
                    cmd.emit_dec  = !status.emit_done;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ rtl/scc_dpath.sv @@
// ----------------------------------------------------------------------------
// scc_dpath
// adjacency memories, search stack, finish lists, counters and result register
// ----------------------------------------------------------------------------
module scc_dpath #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [5:0]        vertex_count,
    input  logic [1:0]        in_operation,
    input  logic [5:0]        in_from,
    input  logic [5:0]        in_to,
    input  scc_pkg::cmd_t     cmd,
    output scc_pkg::status_t  status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        out_vertex,
    output logic [5:0]        out_component,
    output logic [5:0]        out_count,
    output logic              out_last
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // active vertex count, clamped to 1..MAX_VERTICES
    logic [7:0]              cfg8;
    logic [CW-1:0]           n_act;
    logic [MAX_VERTICES-1:0] act_mask;

    assign cfg8 = {2'b00, vertex_count};

    always_comb begin
        if (cfg8 == 8'd0) n_act = CW'(1);
        else if (cfg8 > 8'(MAX_VERTICES)) n_act = CW'(MAX_VERTICES);
        else n_act = CW'(cfg8);
        for (int k = 0; k < MAX_VERTICES; k++) begin
            act_mask[k] = 8'(k) < 8'(n_act);
        end
    end

    // registers
    logic [IW-1:0]           a_reg, b_reg;
    logic                    edge_reg, swapped_reg;
    logic [MAX_VERTICES-1:0] fwd_valid_reg, rev_valid_reg;
    logic [MAX_VERTICES-1:0] white_reg;
    logic [IW-1:0]           top_reg, top_next;
    logic [CW-1:0]           sp_reg, i_reg, done_reg, total_reg;
    logic [CW-1:0]           j_reg, e_reg, cs_reg, label_reg;
    logic                    pass2_reg, emit_mode_reg;
    logic                    out_valid_reg;
    logic [5:0]              out_vertex_reg, out_component_reg, out_count_reg;
    logic                    out_last_reg;

    // memory ports
    logic [MAX_VERTICES-1:0] fwd_q, rev_q, fwd_wdata, rev_wdata;
    logic [IW-1:0]           fwd_raddr, rev_raddr;
    logic [IW-1:0]           stack_q, fin1_q;
    logic [IW:0]             fin2_q;
    logic [CW-1:0]           sp_m1, sp_m2, fin1_idx;

    // search signals
    logic [IW-1:0]           seq_v, cand_idx;
    logic [MAX_VERTICES-1:0] row_t, cand;

    assign sp_m1    = sp_reg - CW'(1);
    assign sp_m2    = sp_reg - CW'(2);
    assign fin1_idx = n_act - CW'(1) - i_reg;

    assign seq_v = pass2_reg ? fin1_q : i_reg[IW-1:0];

    assign row_t = pass2_reg ? (rev_valid_reg[top_reg] ? rev_q : '0)
                             : (fwd_valid_reg[top_reg] ? fwd_q : '0);
    assign cand  = row_t & white_reg;

    // lowest numbered white neighbor
    always_comb begin
        cand_idx = '0;
        for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (cand[k]) cand_idx = IW'(k);
        end
    end

    always_comb begin
        if (cmd.start_tree) top_next = seq_v;
        else if (cmd.push) top_next = cand_idx;
        else if (cmd.pop) top_next = stack_q;
        else top_next = top_reg;
    end

    assign fwd_raddr = cmd.add_rd ? a_reg : top_next;
    assign rev_raddr = cmd.add_rd ? b_reg : top_next;
    assign fwd_wdata = (fwd_valid_reg[a_reg] ? fwd_q : '0) | (MAX_VERTICES'(1) << b_reg);
    assign rev_wdata = (rev_valid_reg[b_reg] ? rev_q : '0) | (MAX_VERTICES'(1) << a_reg);

    scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_fwd_ram (
        .aclk(aclk), .we(cmd.add_wr), .waddr(a_reg), .wdata(fwd_wdata),
        .raddr(fwd_raddr), .rdata(fwd_q)
    );

    scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_rev_ram (
        .aclk(aclk), .we(cmd.add_wr), .waddr(b_reg), .wdata(rev_wdata),
        .raddr(rev_raddr), .rdata(rev_q)
    );

    scc_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .aclk(aclk), .we(cmd.push), .waddr(sp_m1[IW-1:0]), .wdata(top_reg),
        .raddr(sp_m2[IW-1:0]), .rdata(stack_q)
    );

    scc_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_fin1_ram (
        .aclk(aclk), .we(cmd.finish && !pass2_reg), .waddr(done_reg[IW-1:0]),
        .wdata(top_reg), .raddr(fin1_idx[IW-1:0]), .rdata(fin1_q)
    );

    // second-pass finish list, msb marks a tree root
    scc_ram #(.WIDTH(IW + 1), .DEPTH(MAX_VERTICES)) u_fin2_ram (
        .aclk(aclk), .we(cmd.finish && pass2_reg), .waddr(done_reg[IW-1:0]),
        .wdata({sp_reg == CW'(1), top_reg}),
        .raddr(emit_mode_reg ? e_reg[IW-1:0] : j_reg[IW-1:0]), .rdata(fin2_q)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= '0;
            rev_valid_reg <= '0;
            edge_reg      <= 1'b0;
            swapped_reg   <= 1'b0;
            pass2_reg     <= 1'b0;
            emit_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            white_reg     <= '0;
            sp_reg        <= '0;
            i_reg         <= '0;
            done_reg      <= '0;
            total_reg     <= '0;
            j_reg         <= '0;
            e_reg         <= '0;
            cs_reg        <= '0;
            label_reg     <= '0;
        end else begin
            if (cmd.clear_rows) begin
                fwd_valid_reg <= '0;
                rev_valid_reg <= '0;
            end else if (cmd.add_wr) begin
                fwd_valid_reg[a_reg] <= 1'b1;
                rev_valid_reg[b_reg] <= 1'b1;
            end

            if (cmd.latch_add) begin
                edge_reg    <= in_operation == scc_pkg::OP_EDGE;
                swapped_reg <= 1'b0;
            end else if (cmd.add_swap) begin
                swapped_reg <= 1'b1;
            end

            if (cmd.run_init || cmd.begin_pass2) white_reg <= act_mask;
            else if (cmd.start_tree) white_reg[seq_v] <= 1'b0;
            else if (cmd.push) white_reg[cand_idx] <= 1'b0;

            if (cmd.start_tree) sp_reg <= CW'(1);
            else if (cmd.push) sp_reg <= sp_reg + CW'(1);
            else if (cmd.finish) sp_reg <= sp_m1;

            if (cmd.run_init || cmd.begin_pass2) i_reg <= '0;
            else if (cmd.next_seq) i_reg <= i_reg + CW'(1);

            if (cmd.run_init || cmd.begin_pass2) done_reg <= '0;
            else if (cmd.finish) done_reg <= done_reg + CW'(1);

            if (cmd.run_init) total_reg <= '0;
            else if (cmd.start_tree && pass2_reg) total_reg <= total_reg + CW'(1);

            if (cmd.run_init) pass2_reg <= 1'b0;
            else if (cmd.begin_pass2) pass2_reg <= 1'b1;

            if (cmd.begin_scan) begin
                j_reg         <= '0;
                cs_reg        <= '0;
                label_reg     <= CW'(1);
                emit_mode_reg <= 1'b0;
            end else if (cmd.scan_next) begin
                j_reg <= j_reg + CW'(1);
            end else if (cmd.emit_begin) begin
                e_reg         <= j_reg;
                emit_mode_reg <= 1'b1;
            end else if (cmd.emit_dec) begin
                e_reg <= e_reg - CW'(1);
            end else if (cmd.chunk_end) begin
                label_reg     <= label_reg + CW'(1);
                cs_reg        <= j_reg + CW'(1);
                j_reg         <= j_reg + CW'(1);
                emit_mode_reg <= 1'b0;
            end

            if (cmd.load_out) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_add) begin
            a_reg <= IW'(in_from - 6'd1);
            b_reg <= IW'(in_to - 6'd1);
        end else if (cmd.add_swap) begin
            a_reg <= b_reg;
            b_reg <= a_reg;
        end
        top_reg <= top_next;
        if (cmd.load_out) begin
            out_vertex_reg    <= 6'(CW'(fin2_q[IW-1:0]) + CW'(1));
            out_component_reg <= 6'(label_reg);
            out_count_reg     <= 6'(total_reg);
            out_last_reg      <= (j_reg == n_act - CW'(1)) && (e_reg == cs_reg);
        end
    end

    // status
    assign status.in_op     = in_operation;
    assign status.add_ok    = in_from != 6'd0 && in_to != 6'd0 &&
                              {2'b00, in_from} <= 8'(n_act) && {2'b00, in_to} <= 8'(n_act);
    assign status.edge_op   = edge_reg;
    assign status.swapped   = swapped_reg;
    assign status.pass2     = pass2_reg;
    assign status.seq_white = white_reg[seq_v];
    assign status.cand_any  = |cand;
    assign status.sp_one    = sp_reg == CW'(1);
    assign status.i_last    = i_reg == n_act - CW'(1);
    assign status.root_flag = fin2_q[IW];
    assign status.emit_done = e_reg == cs_reg;
    assign status.j_last    = j_reg == n_act - CW'(1);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_vertex    = out_vertex_reg;
    assign out_component = out_component_reg;
    assign out_count     = out_count_reg;
    assign out_last      = out_last_reg;

endmodule

@@ rtl/strongly_connected_components.sv @@
// ----------------------------------------------------------------------------
// strongly_connected_components
// graph loader and two-pass depth-first component finder
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_*       in   op, from, to: add arc, add edge, run, clear
//  m_*       out  vertex, component, component count; tlast on final beat
//  apb       in   vertex_count at byte address 0
//
//  add arc: a read-modify-write on the forward and reverse adjacency rams, one
//  row each per cycle; add edge: two, the second with from and to swapped;
//  clear: drops all row valid bits. run: each search pass reads then checks
//  each start vertex, pushes on a tree arc and pops on a return, through the
//  single row port of each ram; readout reads each result and each finish-list entry scanned
//  synchronous active-low reset clears all rows through row valid bits
//  the input is taken only between commands; a stalled m_tready holds the
//  search readout while the result register is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strongly_connected_components #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[1:0], from_vertex[7:2], to_vertex[13:8]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // vertex[5:0], component[11:6], component_count[17:12]
    output logic        m_tlast
);

    logic [5:0]        vertex_count_reg;
    scc_pkg::cmd_t     cmd;
    scc_pkg::status_t  status;
    logic [5:0]        out_vertex, out_component, out_count;

    // register file: only vertex_count, addressed by paddr[2]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= scc_pkg::VCOUNT_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            vertex_count_reg <= pwdata[5:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {26'd0, vertex_count_reg};

    scc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scc_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .vertex_count  (vertex_count_reg),
        .in_operation  (s_tdata[1:0]),
        .in_from       (s_tdata[7:2]),
        .in_to         (s_tdata[13:8]),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_vertex    (out_vertex),
        .out_component (out_component),
        .out_count     (out_count),
        .out_last      (m_tlast)
    );

    assign m_tdata = {6'd0, out_count, out_component, out_vertex};

    // search steps never overlap
    `SCC_ASSERT(a_one_step, aclk, aresetn, $onehot0({cmd.start_tree, cmd.push, cmd.finish, cmd.pop}), "search steps overlap")
    // a result is never loaded over one not yet taken
    `SCC_ASSERT(a_no_overwrite, aclk, aresetn, cmd.load_out |-> (!m_tvalid || m_tready), "result overwritten")
    // no search work while commands are taken
    `SCC_ASSERT(a_idle_quiet, aclk, aresetn, s_tready |-> !(cmd.push || cmd.finish || cmd.load_out), "work while idle")
    // out of reset the block takes commands
    `SCC_ASSERT(a_reset_ready, aclk, aresetn, !$past(aresetn) |-> s_tready, "not ready after reset")
    // the config port never waits
    `SCC_ASSERT_ALWAYS(a_pready, aclk, pready, "config port stalled")

endmodule

@@ tb/tb_strongly_connected_components.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strongly_connected_components
// self-checking bench for the two-pass component finder
// ----------------------------------------------------------------------------
// graph commands stream in on s_*, the bench keeps its own adjacency matrix
// and runs both depth-first passes itself on every run command, then checks
// each m_* beat against the oldest predicted vertex, component, count and tlast
// ----------------------------------------------------------------------------
module tb_strongly_connected_components;

    typedef struct packed {
        logic [5:0] vtx;
        logic [5:0] comp;
        logic [5:0] total;
        logic       fin;
    } scc_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // operation[1:0], from_vertex[7:2], to_vertex[13:8]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // vertex[5:0], component[11:6], component_count[17:12]
    logic        m_tlast;

    strongly_connected_components dut (.*);

    always #5 aclk = ~aclk;

    // bench copy of graph and register
    logic [31:0] graph_rows [32];
    logic [5:0]  vcount_reg = 6'd32;

    logic [15:0] cmd_queue [$];
    scc_res_t    component_queue [$];
    int          errors = 0;
    int          runs_seen = 0;
    bit          stim_done = 1'b0;

    // one depth-first pass over rows, start order given by order[]
    task automatic dfs_pass(input logic [31:0] rows [32], input int order [32], input int n,
                            output int fin [32], output int parent [32]);
        logic [31:0] white;
        int stk [32];
        int sp, done, s, x, w;
        logic [31:0] cand;
        white = (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 1);
        done = 0;
        for (int i = 0; i < 32; i++) parent[i] = 0;
        for (int i = 0; i < n; i++) begin
            s = order[i];
            if (!white[s]) continue;
            white[s] = 1'b0;
            sp = 0;
            stk[sp++] = s;
            while (sp > 0) begin
                x = stk[sp-1];
                cand = rows[x] & white;
                if (cand != 0) begin
                    w = 0;
                    while (!cand[w]) w++;
                    parent[w] = x + 1;
                    white[w] = 1'b0;
                    stk[sp++] = w;
                end else begin
                    fin[done++] = x;
                    sp--;
                end
            end
        end
    endtask

    task automatic predict_components();
        int n, total, counter;
        logic [31:0] fwd [32];
        logic [31:0] rev [32];
        logic [31:0] mask;
        int order [32];
        int fin1 [32];
        int fin2 [32];
        int par [32];
        int walk [32];
        int label [32];
        int k;
        scc_res_t r;
        n = (vcount_reg == 0) ? 1 : (vcount_reg > 32 ? 32 : vcount_reg);
        mask = (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 1);
        for (int a = 0; a < 32; a++) begin
            fwd[a] = (a < n) ? (graph_rows[a] & mask) : '0;
            rev[a] = '0;
        end
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
                if (fwd[a][b]) rev[b][a] = 1'b1;
        for (int i = 0; i < n; i++) order[i] = i;
        dfs_pass(fwd, order, n, fin1, par);
        for (int i = 0; i < n; i++) order[i] = fin1[n-1-i];
        dfs_pass(rev, order, n, fin2, par);
        total = 0;
        for (int i = 0; i < n; i++) begin
            walk[i] = fin2[n-1-i];
            if (par[walk[i]] == 0) total++;
        end
        counter = total + 1;
        for (int i = 0; i < n; i++) begin
            if (par[walk[i]] == 0) counter--;
            label[walk[i]] = counter;
        end
        k = 0;
        for (int c = 1; c <= total; c++)
            for (int i = 0; i < n; i++) begin
                if (label[walk[i]] != c) continue;
                r.vtx = 6'(walk[i] + 1);
                r.comp = 6'(c);
                r.total = 6'(total);
                r.fin = (k + 1 == n);
                component_queue.push_back(r);
                k++;
            end
    endtask

    // apply a command to the bench graph as it is accepted
    task automatic apply_cmd(input logic [15:0] d);
        logic [1:0] op;
        int u, v, n;
        op = d[1:0];
        u = d[7:2];
        v = d[13:8];
        n = (vcount_reg == 0) ? 1 : (vcount_reg > 32 ? 32 : vcount_reg);
        case (op)
            scc_pkg::OP_CLEAR: begin
                for (int i = 0; i < 32; i++) graph_rows[i] = '0;
            end
            scc_pkg::OP_RUN: begin
                predict_components();
                runs_seen++;
            end
            default: begin
                if (u >= 1 && u <= n && v >= 1 && v <= n) begin
                    graph_rows[u-1][v-1] = 1'b1;
                    if (op == scc_pkg::OP_EDGE) graph_rows[v-1][u-1] = 1'b1;
                end
            end
        endcase
    endtask

    // driver: one beat at a time from the command queue, random gap per beat
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            apply_cmd(s_tdata);
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (cmd_queue.size() > 0 && send_gap == 0) begin
                s_tdata <= cmd_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end else if (!s_tvalid && cmd_queue.size() > 0) begin
            if (send_gap > 0) begin
                send_gap--;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= cmd_queue.pop_front();
            end
        end
    end

    // monitor: random backpressure, each beat checked against the oldest prediction
    int recv_gap = 0;
    always @(posedge aclk) begin
        scc_res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (component_queue.size() == 0) begin
                    $display("%0t: unexpected beat, actual vtx=%0d comp=%0d cnt=%0d last=%0b",
                             $time, m_tdata[5:0], m_tdata[11:6], m_tdata[17:12], m_tlast);
                    errors++;
                end else begin
                    want = component_queue.pop_front();
                    if (m_tdata[5:0] !== want.vtx || m_tdata[11:6] !== want.comp ||
                        m_tdata[17:12] !== want.total || m_tlast !== want.fin) begin
                        $display("%0t: mismatch expected vtx=%0d comp=%0d cnt=%0d last=%0b",
                                 $time, want.vtx, want.comp, want.total, want.fin);
                        $display("%0t:          actual   vtx=%0d comp=%0d cnt=%0d last=%0b",
                                 $time, m_tdata[5:0], m_tdata[11:6], m_tdata[17:12],
                                 m_tlast);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pack_cmd(logic [1:0] op, logic [5:0] u, logic [5:0] v);
        return {2'b00, v, u, op};
    endfunction

    // random graph load followed by a run; mostly in-range vertices
    task automatic queue_random_graph(input int n, input int arcs);
        logic [5:0] u, v;
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_CLEAR, 6'($urandom), 6'($urandom)));
        for (int i = 0; i < arcs; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                u = 6'($urandom);
                v = 6'($urandom);
            end else begin
                u = 6'($urandom_range(1, n));
                v = 6'($urandom_range(1, n));
            end
            cmd_queue.push_back(pack_cmd($urandom_range(0, 3) == 0 ? scc_pkg::OP_EDGE
                                                                   : scc_pkg::OP_ARC, u, v));
        end
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'($urandom), 6'($urandom)));
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || s_tvalid || component_queue.size() > 0)
            @(posedge aclk);
        // runs with no result leave nothing behind, but let the engine settle
        repeat (200) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [5:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= '0; pwdata <= {26'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        vcount_reg = value;
    endtask

    int n_sel;
    initial begin
        for (int i = 0; i < 32; i++) graph_rows[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset count, field extremes, ignored adds, loops, repeats
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'd0, 6'd0));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd1, 6'd32));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd32, 6'd1));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd0, 6'd5));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd63, 6'd5));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_EDGE, 6'd5, 6'd33));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_EDGE, 6'd2, 6'd3));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd4, 6'd4));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd1, 6'd32));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd3, 6'd4));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'd63, 6'd63));
        wait_drained();

        // shrunk count keeps out-of-range arcs in the matrix
        apb_write(6'd4);
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd4, 6'd1));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd5, 6'd1));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'd0, 6'd0));
        wait_drained();
        apb_write(6'd0);
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_ARC, 6'd1, 6'd1));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'd0, 6'd0));
        wait_drained();
        apb_write(6'd63);
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'd0, 6'd0));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_CLEAR, 6'd0, 6'd0));
        cmd_queue.push_back(pack_cmd(scc_pkg::OP_RUN, 6'd0, 6'd0));
        wait_drained();

        // random phases with changing vertex counts, mostly small graphs
        for (int ph = 0; ph < 8; ph++) begin
            n_sel = (ph == 3) ? 32 : (ph == 5 ? 1 : $urandom_range(2, 12));
            apb_write(6'(n_sel));
            for (int g = 0; g < 5; g++)
                queue_random_graph(n_sel, $urandom_range(0, 2 * n_sel + 2));
            wait_drained();
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0 && component_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_ctrl.sv
rtl/scc_dpath.sv
rtl/strongly_connected_components.sv
tb/tb_strongly_connected_components.sv
